// ===== hw/rtl/ordered_list_append_delete_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ordered list block.
// Each macro checks a clocked implication with reset disabling the check.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_APPEND_DELETE_ASSERT_SVH
`define ORDERED_LIST_APPEND_DELETE_ASSERT_SVH

`ifndef ASSERT_OFF

`define OLAD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define OLAD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define OLAD_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define OLAD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/olad_pkg.sv =====
// ----------------------------------------------------------------------------
// olad_pkg
// Shared constants and types for the ordered list cell chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package olad_pkg;

    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int ENTRY_COUNT_W = 5;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_POP    = 2'd2;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic              append_en;
        logic              shift_all;
        logic              delete_en;
        logic [DATA_W-1:0] key;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/olad_cell.sv =====
// ----------------------------------------------------------------------------
// olad_cell
// One list slot: compares its word with the key, passes the hit flag on,
// and loads either the word of its neighbor or an appended value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module olad_cell (
    input  wire logic                       clk,
    input  wire olad_pkg::cell_ctl_t        ctl,
    input  wire logic                       occupied,
    input  wire logic                       is_tail,
    input  wire logic [olad_pkg::DATA_W-1:0] next_data,
    input  wire logic                       hit_in,
    output logic                            hit_out,
    output logic [olad_pkg::DATA_W-1:0]     data_out
);
    import olad_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              match;

    assign match    = occupied & (data_reg == ctl.key);
    assign hit_out  = hit_in | match;
    assign data_out = data_reg;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.shift_all | (ctl.delete_en & (hit_in | match)))
        begin
            data_next = next_data;
        end
        else if (ctl.append_en & is_tail)
        begin
            data_next = ctl.key;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ordered_list_append_delete.sv =====
// A response is valid in the cycle after its request is accepted.
// One request per cycle; a held response blocks cmd_ready until it is taken.
// Delete finds the first match through a hit flag rippled along the cell chain.
// Reset clears count_reg and the response valid flag; entry_count is not reset.
// The slot words are not reset; a slot is read only below the entry count.
// ----------------------------------------------------------------------------
// ordered_list_append_delete
// Bounded ordered list with append at tail, delete by key and pop from head.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ordered_list_append_delete_assert.svh"

module ordered_list_append_delete (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cmd_valid,
    output logic                                    cmd_ready,
    input  wire logic [1:0]                         command,
    input  wire logic signed [olad_pkg::DATA_W-1:0] value,
    output logic                                    res_valid,
    input  wire logic                               res_ready,
    output logic [1:0]                              status,
    output logic [olad_pkg::ENTRY_COUNT_W-1:0]      entry_count
);
    import olad_pkg::*;

    logic [COUNT_W-1:0]       count_reg;
    logic [COUNT_W-1:0]       count_next;
    logic                     res_valid_reg;
    logic [1:0]               status_reg;
    logic [1:0]               status_next;
    logic [ENTRY_COUNT_W-1:0] entry_count_reg;
    logic                     accept;
    logic                     full;
    logic                     empty;
    logic                     found;
    cell_ctl_t                ctl;
    logic [DEPTH:0]           hit;
    logic [DATA_W-1:0]        cell_data [DEPTH];

    assign cmd_ready   = ~res_valid_reg | res_ready;
    assign accept      = cmd_valid & cmd_ready;
    assign full        = (count_reg == COUNT_W'(DEPTH));
    assign empty       = (count_reg == '0);
    assign found       = hit[DEPTH];
    assign res_valid   = res_valid_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;

    assign ctl.append_en = accept & (command == CMD_APPEND) & ~full;
    assign ctl.shift_all = accept & (command == CMD_POP) & ~empty;
    assign ctl.delete_en = accept & (command == CMD_DELETE);
    assign ctl.key       = DATA_W'(unsigned'(value));

    assign hit[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_W-1:0] next_data;

        if (i == DEPTH - 1)
        begin : g_last
            assign next_data = cell_data[i];
        end
        else
        begin : g_mid
            assign next_data = cell_data[i + 1];
        end

        olad_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .occupied  (COUNT_W'(i) < count_reg),
            .is_tail   (COUNT_W'(i) == count_reg),
            .next_data (next_data),
            .hit_in    (hit[i]),
            .hit_out   (hit[i + 1]),
            .data_out  (cell_data[i])
        );
    end

    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_DONE;
        case (command)
            CMD_APPEND:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            CMD_DELETE:
            begin
                if (found)
                begin
                    count_next = count_reg - COUNT_W'(1);
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            CMD_POP:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - COUNT_W'(1);
                end
            end
            default:
            begin
                count_next  = count_reg;
                status_next = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg      <= status_next;
            entry_count_reg <= ENTRY_COUNT_W'(count_next);
        end
    end

    `OLAD_ASSERT_SAME(a_count_range, clk, rst_n, 1'b1, count_reg <= COUNT_W'(DEPTH))
    `OLAD_ASSERT_NEXT(a_accept_gives_response, clk, rst_n, accept, res_valid_reg)
    `OLAD_ASSERT_NEXT(a_full_drop, clk, rst_n, accept && command == CMD_APPEND && full, status_reg == ST_FULL && count_reg == $past(count_reg))
    `OLAD_ASSERT_NEXT(a_pop_empty, clk, rst_n, accept && command == CMD_POP && empty, status_reg == ST_EMPTY && count_reg == '0)

endmodule

`default_nettype wire
